>>> hw/rtl/kvp_pkg.sv
// shared types and constants of the key=value command line parser
// no dependencies; imported by all parser modules
package kvp_pkg;

  localparam logic [2:0] CMD_UNKNOWN = 3'd0;
  localparam logic [2:0] CMD_HELP    = 3'd1;
  localparam logic [2:0] CMD_MAX     = 3'd2;
  localparam logic [2:0] CMD_PERIOD  = 3'd3;
  localparam logic [2:0] CMD_KP      = 3'd4;
  localparam logic [2:0] CMD_KI      = 3'd5;
  localparam logic [2:0] CMD_KD      = 3'd6;
  localparam logic [2:0] CMD_DRIVE   = 3'd7;

  localparam int NUM_KEYS = 6;
  localparam int FRAC_BITS = 16;
  localparam int VALUE_W = 49;

  localparam logic [7:0] CHR_LF    = 8'd10;
  localparam logic [7:0] CHR_CR    = 8'd13;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_TILDE = 8'h7e;
  localparam logic [7:0] CHR_EQ    = 8'h3d;
  localparam logic [7:0] CHR_MINUS = 8'h2d;
  localparam logic [7:0] CHR_PLUS  = 8'h2b;
  localparam logic [7:0] CHR_DOT   = 8'h2e;
  localparam logic [7:0] CHR_COMMA = 8'h2c;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  typedef struct packed {
    logic walk;
    logic div_start;
    logic finish;
  } kvp_cmd_t;

  typedef struct packed {
    logic eol_hit;
    logic last_issue;
    logic div_busy;
    logic out_free;
  } kvp_status_t;

  // key order: max, period, p, i, d, drive
  function automatic logic [2:0] key_len(input logic [2:0] k);
    unique case (k)
      3'd0: key_len = 3'd3;
      3'd1: key_len = 3'd6;
      3'd5: key_len = 3'd5;
      default: key_len = 3'd1;
    endcase
  endfunction

  function automatic logic [7:0] key_char(input logic [2:0] k, input logic [2:0] j);
    logic [47:0] s;
    s = 48'h0;
    unique case (k)
      3'd0: s = 48'h00_00_00_78_61_6d;
      3'd1: s = 48'h64_6f_69_72_65_70;
      3'd2: s = 48'h00_00_00_00_00_70;
      3'd3: s = 48'h00_00_00_00_00_69;
      3'd4: s = 48'h00_00_00_00_00_64;
      default: s = 48'h00_65_76_69_72_64;
    endcase
    key_char = (j < 3'd6) ? s[8*j +: 8] : 8'h00;
  endfunction

  function automatic logic [7:0] help_char(input logic [1:0] j);
    unique case (j)
      2'd0: help_char = 8'h68;
      2'd1: help_char = 8'h65;
      2'd2: help_char = 8'h6c;
      default: help_char = 8'h70;
    endcase
  endfunction

endpackage

>>> hw/rtl/kvp_fracdiv.sv
// restoring divider for the fraction: floor(numer * 2^16 / denom), numer < denom
// one quotient bit per cycle; uses kvp_pkg
module kvp_fracdiv #(
  parameter int NW = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [NW-1:0]                 numer,
  input  logic [NW-1:0]                 denom,
  output logic                          busy,
  output logic [kvp_pkg::FRAC_BITS-1:0] quot
);
  import kvp_pkg::*;

  logic [NW:0] rem;
  logic [NW:0] shifted;
  logic [4:0]  cnt;
  logic        take;

  assign shifted = {rem[NW-1:0], 1'b0};
  assign take = shifted >= {1'b0, denom};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'(FRAC_BITS);
      rem  <= {1'b0, numer};
      quot <= '0;
    end else if (busy) begin
      rem  <= take ? shifted - {1'b0, denom} : shifted;
      quot <= {quot[FRAC_BITS-2:0], take};
      cnt  <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/kvp_dp.sv
// datapath: line store, key and number scan, fraction divider, result register
// uses kvp_pkg and kvp_fracdiv
module kvp_dp #(
  parameter int LINE_CAPACITY  = 64,
  parameter int FRACTION_LIMIT = 1000000
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_fire,
  input  logic [7:0]                  char_code,
  input  kvp_pkg::kvp_cmd_t           cmd,
  output kvp_pkg::kvp_status_t        status,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [2:0]                  command,
  output logic [1:0]                  gain_set,
  output logic                        gain_ignored,
  output logic [kvp_pkg::VALUE_W-1:0] applied_value
);
  import kvp_pkg::*;

  localparam int IW = $clog2(LINE_CAPACITY);
  localparam int SW = $clog2(FRACTION_LIMIT * 10);

  typedef enum logic [1:0] {NUM_SIGN, NUM_INT, NUM_FRAC} num_state_t;

  logic [7:0]    store [LINE_CAPACITY];
  logic [IW-1:0] len;
  logic [IW-1:0] idx;
  logic [IW-1:0] pos;
  logic          pv;
  logic [7:0]    rd;
  logic [1:0]    drive_mode;

  logic [NUM_KEYS-1:0] km;
  logic [NUM_KEYS-1:0] kd;
  logic                hm;
  logic                num_on;
  num_state_t          ns;
  logic                bad;
  logic                dig;
  logic                neg;
  logic [31:0]         whole;
  logic [SW-1:0]       fr;
  logic [SW-1:0]       sc;

  logic        is_eol;
  logic        is_print;
  logic        c_digit;
  logic        c_dot;
  logic [3:0]  dval;
  logic [35:0] w10;
  logic        key_hit;
  logic [NUM_KEYS-1:0] km_next;
  logic [NUM_KEYS-1:0] kd_next;
  logic [FRAC_BITS-1:0] qfrac;
  logic        div_busy;

  assign is_eol   = (char_code == CHR_LF) || (char_code == CHR_CR);
  assign is_print = (char_code >= CHR_SPACE) && (char_code <= CHR_TILDE);
  assign c_digit  = (rd >= CHR_ZERO) && (rd <= CHR_NINE);
  assign c_dot    = (rd == CHR_DOT) || (rd == CHR_COMMA);
  assign dval     = 4'(rd - CHR_ZERO);
  assign w10      = {1'b0, whole, 3'b0} + {3'b0, whole, 1'b0} + {32'b0, dval};

  always_comb begin
    km_next = km;
    kd_next = kd;
    key_hit = 1'b0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (pos < IW'(key_len(3'(k)))) begin
        if (rd != key_char(3'(k), pos[2:0])) begin
          km_next[k] = 1'b0;
        end
      end else if (pos == IW'(key_len(3'(k)))) begin
        if (km[k] && rd == CHR_EQ) begin
          kd_next[k] = 1'b1;
          key_hit = 1'b1;
        end
        km_next[k] = 1'b0;
      end
    end
  end

  // line store and scan
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      pv  <= 1'b0;
    end else begin
      pv <= cmd.walk;
      if (in_fire && is_print && len < IW'(LINE_CAPACITY - 1)) begin
        store[len] <= char_code;
        len <= len + 1'b1;
      end
      if (cmd.finish) begin
        len <= '0;
      end
    end
    if (cmd.walk) begin
      rd  <= store[idx];
      pos <= idx;
      idx <= idx + 1'b1;
    end
    if (in_fire && is_eol) begin
      idx    <= '0;
      km     <= '1;
      kd     <= '0;
      hm     <= 1'b1;
      num_on <= 1'b0;
      ns     <= NUM_SIGN;
      bad    <= 1'b0;
      dig    <= 1'b0;
      neg    <= 1'b0;
      whole  <= '0;
      fr     <= '0;
      sc     <= SW'(1);
    end else if (pv) begin
      km <= km_next;
      kd <= kd_next;
      if (pos < IW'(4) && rd != help_char(pos[1:0])) begin
        hm <= 1'b0;
      end
      if (key_hit) begin
        num_on <= 1'b1;
      end
      if (num_on) begin
        unique case (ns)
          NUM_SIGN, NUM_INT: begin
            if (c_digit) begin
              dig   <= 1'b1;
              ns    <= NUM_INT;
              whole <= (w10 > 36'hffff_ffff) ? 32'hffff_ffff : w10[31:0];
            end else if (c_dot) begin
              ns <= NUM_FRAC;
            end else if (ns == NUM_SIGN && rd == CHR_MINUS) begin
              neg <= 1'b1;
              ns  <= NUM_INT;
            end else if (ns == NUM_SIGN && rd == CHR_PLUS) begin
              ns <= NUM_INT;
            end else begin
              bad <= 1'b1;
            end
          end
          NUM_FRAC: begin
            if (c_digit) begin
              dig <= 1'b1;
              if (sc < SW'(FRACTION_LIMIT)) begin
                fr <= SW'({1'b0, fr, 3'b0} + {3'b0, fr, 1'b0} + {{SW{1'b0}}, dval});
                sc <= SW'({sc, 3'b0} + {2'b0, sc, 1'b0});
              end
            end else begin
              bad <= 1'b1;
            end
          end
          default: bad <= 1'b1;
        endcase
      end
    end
  end

  kvp_fracdiv #(.NW(SW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .numer (fr),
    .denom (sc),
    .busy  (div_busy),
    .quot  (qfrac)
  );

  // result
  logic                num_ok;
  logic [2:0]          r_cmd;
  logic [1:0]          r_set;
  logic                r_ign;
  logic [VALUE_W-1:0]  r_val;
  logic [31:0]         sat_mag;
  logic [32:0]         neg_v;
  logic [1:0]          drv;

  assign num_ok  = dig && !bad;
  assign sat_mag = (whole > 32'h8000_0000) ? 32'h8000_0000 : whole;
  assign neg_v   = 33'd0 - {1'b0, sat_mag};
  assign drv     = neg ? 2'd0 : ((whole > 32'd3) ? 2'd3 : whole[1:0]);

  always_comb begin
    r_cmd = CMD_UNKNOWN;
    r_set = 2'd0;
    r_ign = 1'b0;
    r_val = '0;
    if (len == IW'(4) && hm) begin
      r_cmd = CMD_HELP;
    end else if (num_ok) begin
      priority if (kd[0]) begin
        r_cmd = CMD_MAX;
        if (neg) begin
          r_val = {{(VALUE_W-33){neg_v[32]}}, neg_v};
        end else begin
          r_val = (whole > 32'h7fff_ffff) ? VALUE_W'(32'h7fff_ffff) : VALUE_W'(whole);
        end
      end else if (kd[1]) begin
        r_cmd = CMD_PERIOD;
        r_val = (whole > 32'd127) ? VALUE_W'(127) : VALUE_W'(whole);
      end else if (kd[5]) begin
        r_cmd = CMD_DRIVE;
        r_val = VALUE_W'(drv);
      end else if (kd[2] || kd[3] || kd[4]) begin
        r_cmd = kd[2] ? CMD_KP : (kd[3] ? CMD_KI : CMD_KD);
        if (drive_mode == 2'd0) begin
          r_ign = 1'b1;
        end else begin
          r_set = drive_mode - 2'd1;
          r_val = {1'b0, whole, qfrac};
        end
      end else begin
        r_cmd = CMD_UNKNOWN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      drive_mode <= 2'd0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (r_cmd == CMD_DRIVE) begin
          drive_mode <= drv;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (cmd.finish) begin
      command       <= r_cmd;
      gain_set      <= r_set;
      gain_ignored  <= r_ign;
      applied_value <= r_val;
    end
  end

  assign status.eol_hit    = is_eol && (len != '0);
  assign status.last_issue = (idx == len - 1'b1);
  assign status.div_busy   = div_busy;
  assign status.out_free   = !out_valid || out_ready;

endmodule

>>> hw/rtl/kvp_ctrl.sv
// controller state machine of the parser
// uses kvp_pkg; drives kvp_dp through command and status structs
module kvp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  kvp_pkg::kvp_status_t status,
  output kvp_pkg::kvp_cmd_t    cmd
);
  import kvp_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_WALK, S_DRAIN, S_DIV, S_WAIT, S_FIN} state_t;

  state_t state;

  assign in_ready      = (state == S_IDLE);
  assign cmd.walk      = (state == S_WALK);
  assign cmd.div_start = (state == S_DIV);
  assign cmd.finish    = (state == S_FIN) && status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && status.eol_hit) begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (status.last_issue) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_DIV;
        S_DIV:   state <= S_WAIT;
        S_WAIT: begin
          if (!status.div_busy) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/key_value_command_line_parser.sv
// top level of the key=value command line parser
// uses kvp_pkg, kvp_ctrl and kvp_dp
//
// Characters are taken one per cycle while the parser is idle; none is taken
// while a line is decoded. A CR or LF after a non-empty line starts the decode:
// the stored line is read back one character per cycle from the line store,
// then the fraction is converted by a one-bit-per-cycle divider. A decoded
// result sits in an output register; the decode ends only once that register
// is free, and no further character is taken until then.
module key_value_command_line_parser #(
  parameter int LINE_CAPACITY  = 64,
  parameter int FRACTION_LIMIT = 1000000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // char_code[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata   // command[2:0], gain_set[4:3], gain_ignored[5],
                                     // applied_value[54:6], zero[55]
);
  import kvp_pkg::*;

  kvp_cmd_t    cmd;
  kvp_status_t status;
  logic        in_fire;
  logic [2:0]  command;
  logic [1:0]  gain_set;
  logic        gain_ignored;
  logic [VALUE_W-1:0] applied_value;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  kvp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  kvp_dp #(
    .LINE_CAPACITY  (LINE_CAPACITY),
    .FRACTION_LIMIT (FRACTION_LIMIT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .in_fire       (in_fire),
    .char_code     (s_axis_tdata),
    .cmd           (cmd),
    .status        (status),
    .out_ready     (m_axis_tready),
    .out_valid     (m_axis_tvalid),
    .command       (command),
    .gain_set      (gain_set),
    .gain_ignored  (gain_ignored),
    .applied_value (applied_value)
  );

  assign m_axis_tdata = {1'b0, applied_value, gain_ignored, gain_set, command};

  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && command == CMD_UNKNOWN) |-> (applied_value == '0 && !gain_ignored))
    else $error("unknown command carries a value");

  a_ignored_gain: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && gain_ignored) |->
      ((command == CMD_KP || command == CMD_KI || command == CMD_KD) && applied_value == '0))
    else $error("ignored flag on a non-gain command");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && command == CMD_DRIVE) |-> (applied_value <= VALUE_W'(3)))
    else $error("drive mode out of range");

endmodule

>>> tb/sv/key_value_command_line_parser_tb.sv
// testbench of the key=value command line parser: streams characters, predicts each
// decoded line and compares every result transfer field by field
// depends on kvp_pkg and key_value_command_line_parser
module key_value_command_line_parser_tb;
  import kvp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_MAX = 63;
  localparam int FRAC_LIMIT = 1000000;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [48:0] applied_value;
    logic        gain_ignored;
    logic [1:0]  gain_set;
    logic [2:0]  command;
  } line_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  always #5 clk = ~clk;

  key_value_command_line_parser u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  logic [7:0] char_queue[$];
  line_result_t decoded_queue[$];
  logic [7:0] line_buf[STORE_MAX];
  int line_len = 0;
  logic [1:0] mode = 2'd0;
  int errors = 0;
  bit calm = 1'b0;
  bit hold = 1'b0;
  bit stim_done = 1'b0;
  int quiet = 0;

  function automatic bit is_digit(logic [7:0] c);
    return c >= CHR_ZERO && c <= CHR_NINE;
  endfunction

  function automatic line_result_t decode_line();
    line_result_t r;
    string keys[6];
    int found, n, p;
    bit ok, neg, digit;
    logic [63:0] w, fr, sc, qf;
    logic signed [63:0] v;
    r = '0;
    keys = '{"max", "period", "p", "i", "d", "drive"};
    if (line_len == 4 && line_buf[0] == "h" && line_buf[1] == "e" && line_buf[2] == "l" &&
        line_buf[3] == "p") begin
      r.command = CMD_HELP;
      return r;
    end
    found = -1;
    for (int k = 0; k < 6 && found < 0; k++) begin
      n = keys[k].len();
      ok = n < line_len;
      for (int j = 0; ok && j < n; j++) if (line_buf[j] != keys[k][j]) ok = 1'b0;
      if (ok && line_buf[n] == CHR_EQ) found = k;
    end
    if (found < 0) return r;
    p = keys[found].len() + 1;
    neg = 1'b0; digit = 1'b0; w = 0; fr = 0; sc = 1;
    if (p < line_len && line_buf[p] == CHR_MINUS) begin neg = 1'b1; p++; end
    else if (p < line_len && line_buf[p] == CHR_PLUS) p++;
    while (p < line_len && is_digit(line_buf[p])) begin
      digit = 1'b1;
      w = w * 10 + (line_buf[p] - CHR_ZERO);
      if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
      p++;
    end
    if (p < line_len && (line_buf[p] == CHR_DOT || line_buf[p] == CHR_COMMA)) begin
      p++;
      while (p < line_len && is_digit(line_buf[p])) begin
        digit = 1'b1;
        if (sc < FRAC_LIMIT) begin
          fr = fr * 10 + (line_buf[p] - CHR_ZERO);
          sc = sc * 10;
        end
        p++;
      end
    end
    if (!digit || p != line_len) return r;
    qf = (fr * 65536) / sc;
    case (found)
      0: begin
        if (neg) v = (w > 64'h8000_0000) ? -64'sh8000_0000 : -$signed(w);
        else v = (w > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : $signed(w);
        r.command = CMD_MAX;
        r.applied_value = v[48:0];
      end
      1: begin
        r.command = CMD_PERIOD;
        r.applied_value = (w > 127) ? 49'd127 : w[48:0];
      end
      5: begin
        mode = neg ? 2'd0 : ((w > 3) ? 2'd3 : w[1:0]);
        r.command = CMD_DRIVE;
        r.applied_value = {47'd0, mode};
      end
      default: begin
        r.command = (found == 2) ? CMD_KP : (found == 3) ? CMD_KI : CMD_KD;
        if (mode == 2'd0) r.gain_ignored = 1'b1;
        else begin
          r.gain_set = mode - 2'd1;
          r.applied_value = ((w << 16) | qf) & 64'h1_FFFF_FFFF_FFFF;
        end
      end
    endcase
    return r;
  endfunction

  task automatic predict_char(logic [7:0] c);
    if (c == CHR_LF || c == CHR_CR) begin
      if (line_len > 0) begin
        decoded_queue.push_back(decode_line());
        line_len = 0;
      end
    end else if (c >= CHR_SPACE && c <= CHR_TILDE && line_len < STORE_MAX) begin
      line_buf[line_len] = c;
      line_len++;
    end
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) char_queue.push_back(s[i]);
  endtask

  task automatic add_line(string s);
    add_text(s);
    char_queue.push_back($urandom_range(1) ? CHR_LF : CHR_CR);
  endtask

  function automatic string rand_number();
    string s, d;
    int n;
    s = "";
    case ($urandom_range(3))
      0: s = "-";
      1: s = "+";
      default: ;
    endcase
    n = ($urandom_range(9) == 0) ? $urandom_range(14) : $urandom_range(3);
    for (int i = 0; i < n; i++) begin d.itoa($urandom_range(9)); s = {s, d}; end
    if ($urandom_range(1)) begin
      if ($urandom_range(1)) s = {s, "."};
      else s = {s, ","};
      n = $urandom_range(9);
      for (int i = 0; i < n; i++) begin d.itoa($urandom_range(9)); s = {s, d}; end
    end
    return s;
  endfunction

  task automatic add_random_line();
    string keys[8];
    string s;
    byte c;
    keys = '{"max=", "period=", "p=", "i=", "d=", "drive=", "help", "dr="};
    case ($urandom_range(9))
      0: begin
        s = "";
        for (int i = $urandom_range(70); i > 0; i--) begin
          c = byte'($urandom_range(255));
          s = {s, string'(c)};
        end
        add_text(s);
        char_queue.push_back(CHR_LF);
      end
      1: add_line({keys[$urandom_range(7)], rand_number(), "x"});
      2: add_line({"drive=", rand_number()});
      default: begin
        s = keys[$urandom_range(6)];
        if (s != "help") s = {s, rand_number()};
        if ($urandom_range(7) == 0) char_queue.push_back(8'($urandom_range(31)));
        add_line(s);
      end
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) predict_char(s_axis_tdata);
      if ((!s_axis_tvalid || s_axis_tready) ) begin
        if (char_queue.size() > 0 && !hold && (calm || $urandom_range(99) >= 11)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= char_queue.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    line_result_t got, want;
    if (!rst) begin
      m_axis_tready <= calm || $urandom_range(99) >= 11;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[54:0];
        if (decoded_queue.size() == 0) begin
          $error("result transfer with nothing expected: %h", m_axis_tdata);
          errors++;
        end else begin
          want = decoded_queue.pop_front();
          if (got.command != want.command) begin
            $error("command expected %0d actual %0d", want.command, got.command); errors++;
          end
          if (got.gain_set != want.gain_set) begin
            $error("gain_set expected %0d actual %0d", want.gain_set, got.gain_set); errors++;
          end
          if (got.gain_ignored != want.gain_ignored) begin
            $error("gain_ignored expected %0d actual %0d", want.gain_ignored,
                   got.gain_ignored);
            errors++;
          end
          if (got.applied_value != want.applied_value) begin
            $error("applied_value expected %h actual %h", want.applied_value,
                   got.applied_value);
            errors++;
          end
        end
      end
    end
  end

  // watchdog and end of run
  always @(posedge clk) begin
    if (quiet >= STALL_LIMIT) begin
      $display("FAIL key_value_command_line_parser");
      $finish;
    end
  end

  initial begin
    string s;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    add_line("help");
    add_line("p=1.5");
    add_line("drive=2");
    add_line("p=1.5");
    add_line("i=-0,000001");
    add_line("d=4294967295.9999999");
    add_line("max=99999999999");
    add_line("max=-2147483649");
    add_line("max=-0.5");
    add_line("period=-200");
    add_line("period=");
    add_line("drive=-0");
    add_line("d=2");
    add_line("drive=9");
    add_line("i=+.25");
    add_line("helpx");
    add_text("\001\377");
    char_queue.push_back(CHR_LF);
    char_queue.push_back(CHR_CR);
    s = "max=";
    for (int i = 0; i < 70; i++) s = {s, "1"};
    add_line(s);
    add_line("~ zz");
    calm = 1'b1;
    wait (char_queue.size() == 0);
    calm = 1'b0;
    hold = 1'b1;
    wait (decoded_queue.size() == 0 && !s_axis_tvalid);
    hold = 1'b0;
    for (int n = 0; n < 38; n++) begin
      calm = (n >= 15 && n < 25);
      add_random_line();
      wait (char_queue.size() < 20);
    end
    wait (char_queue.size() == 0);
    @(posedge clk);
    wait (decoded_queue.size() == 0 && !s_axis_tvalid);
    repeat (200) @(posedge clk);
    if (errors == 0 && decoded_queue.size() == 0) $display("PASS key_value_command_line_parser");
    else $display("FAIL key_value_command_line_parser");
    $finish;
  end
endmodule

>>> key_value_command_line_parser.f
hw/rtl/kvp_pkg.sv
hw/rtl/kvp_fracdiv.sv
hw/rtl/kvp_dp.sv
hw/rtl/kvp_ctrl.sv
hw/rtl/key_value_command_line_parser.sv
tb/sv/key_value_command_line_parser_tb.sv
